/* rtl/tsbc_pkg.sv */
`default_nettype none

package tsbc_pkg;

    localparam int unsigned VERTEX_SLOTS_DEF = 1024;
    localparam int unsigned COORD_FRAC_BITS  = 8;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned IDX_W     = 32;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned FRAME_W   = 13;
    localparam int unsigned LIMIT_W   = 11;
    localparam int unsigned BOX_LO_W  = 15;
    localparam int unsigned BOX_HI_W  = 16;
    localparam int unsigned AREA_W    = 52;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 4;

    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_VERTEX_LIMIT    = 3'd2,
        REG_CULL_ENABLE     = 3'd3,
        REG_CLOCKWISE_FRONT = 3'd4
    } t_reg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TRI  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_B,
        RD_C,
        RD_CAP
    } t_rd_state;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [LIMIT_W-1:0] vertex_limit;
        logic               cull_enable;
        logic               clockwise_front;
    } t_cfg;

    typedef struct packed {
        logic is_tri;
        logic bad_index;
        logic last;
    } t_cmd_ctl;

    typedef struct packed {
        logic                      finite;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    typedef struct packed {
        logic                status;
        logic                candidate;
        logic [BOX_LO_W-1:0] box_x0;
        logic [BOX_HI_W-1:0] box_x1;
        logic [BOX_LO_W-1:0] box_y0;
        logic [BOX_HI_W-1:0] box_y1;
        logic [AREA_W-1:0]   twice_area;
        logic                batch_last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/triangle_setup_bbox_cull.sv */
// Triangle setup: bounding box, doubled area and winding cull.
// Input queue (push/full): a vertex load writes one projected vertex into the
// store and gives no result; a triangle item names three vertex indices and
// gives exactly one result. Results leave in input order through the output
// queue (empty/pop); the head result stays on the o_ ports until popped.
// Registers sit on an APB port at byte offsets 0, 4, 8, 12, 16; write them
// only while no triangle is outstanding. pready is tied high.
// The single-port vertex store is read once per vertex of a valid triangle
// and written once per load; the next triangle's first read can share the
// capture step of the one before when a result slot is free. A triangle
// with a bad index skips the store and enters the pipeline straight from
// the command queue.
// A four-entry command queue and a four-entry result queue decouple the two
// sides: when pop is held low, up to four results wait, then the command
// queue fills and full rises. Synchronous reset empties both queues and
// restores the registers; the vertex store keeps whatever it held, and a
// triangle must only name vertices loaded since power-up.
`default_nettype none

module triangle_setup_bbox_cull #(
    parameter int unsigned VERTEX_SLOTS = tsbc_pkg::VERTEX_SLOTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_kind,
    input  wire logic        [tsbc_pkg::SLOT_W-1:0]  i_vertex_slot,
    input  wire logic signed [tsbc_pkg::COORD_W-1:0] i_vertex_x,
    input  wire logic signed [tsbc_pkg::COORD_W-1:0] i_vertex_y,
    input  wire logic                                i_vertex_finite,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]   i_corner_a,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]   i_corner_b,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]   i_corner_c,
    input  wire logic                                i_batch_end,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     o_status,
    output logic                                     o_candidate,
    output logic        [tsbc_pkg::BOX_LO_W-1:0]     o_box_x0,
    output logic signed [tsbc_pkg::BOX_HI_W-1:0]     o_box_x1,
    output logic        [tsbc_pkg::BOX_LO_W-1:0]     o_box_y0,
    output logic signed [tsbc_pkg::BOX_HI_W-1:0]     o_box_y1,
    output logic signed [tsbc_pkg::AREA_W-1:0]       o_twice_area,
    output logic                                     o_batch_last,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [tsbc_pkg::PADDR_W-1:0] paddr,
    input  wire logic        [tsbc_pkg::PDATA_W-1:0] pwdata,
    output logic             [tsbc_pkg::PDATA_W-1:0] prdata,
    output logic                                     pready
);

    localparam int unsigned ADDR_W = $clog2(VERTEX_SLOTS);

    tsbc_pkg::t_cfg         r_cfg;
    tsbc_pkg::t_reg_idx     reg_idx;
    logic                   cfg_write;

    logic                   cmd_valid;
    tsbc_pkg::t_cmd_ctl     cmd_ctl;
    logic [2:0][ADDR_W-1:0] cmd_addr;
    tsbc_pkg::t_vertex      cmd_vertex;
    logic                   cmd_pop;
    tsbc_pkg::t_result      result;

    assign pready    = 1'b1;
    assign reg_idx   = tsbc_pkg::t_reg_idx'(paddr[tsbc_pkg::PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= tsbc_pkg::FRAME_W'(1);
            r_cfg.frame_height    <= tsbc_pkg::FRAME_W'(1);
            r_cfg.vertex_limit    <= '0;
            r_cfg.cull_enable     <= 1'b0;
            r_cfg.clockwise_front <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                tsbc_pkg::REG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= pwdata[tsbc_pkg::FRAME_W-1:0];
                end
                tsbc_pkg::REG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= pwdata[tsbc_pkg::FRAME_W-1:0];
                end
                tsbc_pkg::REG_VERTEX_LIMIT: begin
                    r_cfg.vertex_limit <= pwdata[tsbc_pkg::LIMIT_W-1:0];
                end
                tsbc_pkg::REG_CULL_ENABLE: begin
                    r_cfg.cull_enable <= pwdata[0];
                end
                tsbc_pkg::REG_CLOCKWISE_FRONT: begin
                    r_cfg.clockwise_front <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tsbc_pkg::REG_FRAME_WIDTH:     prdata = tsbc_pkg::PDATA_W'(r_cfg.frame_width);
            tsbc_pkg::REG_FRAME_HEIGHT:    prdata = tsbc_pkg::PDATA_W'(r_cfg.frame_height);
            tsbc_pkg::REG_VERTEX_LIMIT:    prdata = tsbc_pkg::PDATA_W'(r_cfg.vertex_limit);
            tsbc_pkg::REG_CULL_ENABLE:     prdata = tsbc_pkg::PDATA_W'(r_cfg.cull_enable);
            tsbc_pkg::REG_CLOCKWISE_FRONT: prdata = tsbc_pkg::PDATA_W'(r_cfg.clockwise_front);
            default:                       prdata = '0;
        endcase
    end

    tsbc_front #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_vertex_slot   (i_vertex_slot),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_vertex_finite (i_vertex_finite),
        .i_corner_a      (i_corner_a),
        .i_corner_b      (i_corner_b),
        .i_corner_c      (i_corner_c),
        .i_batch_end     (i_batch_end),
        .o_cmd_valid     (cmd_valid),
        .o_cmd_ctl       (cmd_ctl),
        .o_cmd_addr      (cmd_addr),
        .o_cmd_vertex    (cmd_vertex),
        .i_cmd_pop       (cmd_pop)
    );

    tsbc_back #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ctl    (cmd_ctl),
        .i_cmd_addr   (cmd_addr),
        .i_cmd_vertex (cmd_vertex),
        .o_cmd_pop    (cmd_pop),
        .i_res_pop    (pop),
        .o_res_empty  (empty),
        .o_result     (result)
    );

    assign o_status     = result.status;
    assign o_candidate  = result.candidate;
    assign o_box_x0     = result.box_x0;
    assign o_box_x1     = result.box_x1;
    assign o_box_y0     = result.box_y0;
    assign o_box_y1     = result.box_y1;
    assign o_twice_area = result.twice_area;
    assign o_batch_last = result.batch_last;

endmodule

`default_nettype wire

/* rtl/tsbc_fifo.sv */
`default_nettype none

module tsbc_fifo #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/tsbc_front.sv */
`default_nettype none

module tsbc_front #(
    parameter int unsigned VERTEX_SLOTS = tsbc_pkg::VERTEX_SLOTS_DEF,
    localparam int unsigned ADDR_W = $clog2(VERTEX_SLOTS)
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire tsbc_pkg::t_cfg                          i_cfg,
    input  wire logic                                    i_push,
    output logic                                         o_full,
    input  wire logic                                    i_kind,
    input  wire logic        [tsbc_pkg::SLOT_W-1:0]      i_vertex_slot,
    input  wire logic signed [tsbc_pkg::COORD_W-1:0]     i_vertex_x,
    input  wire logic signed [tsbc_pkg::COORD_W-1:0]     i_vertex_y,
    input  wire logic                                    i_vertex_finite,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]       i_corner_a,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]       i_corner_b,
    input  wire logic signed [tsbc_pkg::IDX_W-1:0]       i_corner_c,
    input  wire logic                                    i_batch_end,
    output logic                                         o_cmd_valid,
    output tsbc_pkg::t_cmd_ctl                           o_cmd_ctl,
    output logic             [2:0][ADDR_W-1:0]           o_cmd_addr,
    output tsbc_pkg::t_vertex                            o_cmd_vertex,
    input  wire logic                                    i_cmd_pop
);

    localparam int unsigned CMD_W =
        $bits(tsbc_pkg::t_cmd_ctl) + 3 * ADDR_W + $bits(tsbc_pkg::t_vertex);

    // An index is usable only if it is non-negative and below both the
    // programmed vertex count and the store depth.
    function automatic logic index_ok(input logic [tsbc_pkg::IDX_W-1:0] idx,
                                      input logic [tsbc_pkg::LIMIT_W-1:0] limit);
        logic below_limit;
        logic below_depth;
        below_limit = idx < tsbc_pkg::IDX_W'(limit);
        below_depth = idx < tsbc_pkg::IDX_W'(VERTEX_SLOTS);
        return !idx[tsbc_pkg::IDX_W-1] && below_limit && below_depth;
    endfunction

    tsbc_pkg::t_cmd_ctl  ctl;
    tsbc_pkg::t_vertex   vertex;
    logic [2:0][ADDR_W-1:0] addr;
    logic                is_tri;
    logic                slot_ok;
    logic                all_ok;
    logic                accept;
    logic                enqueue;
    logic                cmd_empty;
    logic [CMD_W-1:0]    cmd_wdata;
    logic [CMD_W-1:0]    cmd_rdata;

    assign is_tri  = (tsbc_pkg::t_kind'(i_kind) == tsbc_pkg::KIND_TRI);
    assign slot_ok = tsbc_pkg::IDX_W'(i_vertex_slot) < tsbc_pkg::IDX_W'(VERTEX_SLOTS);
    assign all_ok  = index_ok(i_corner_a, i_cfg.vertex_limit)
                  && index_ok(i_corner_b, i_cfg.vertex_limit)
                  && index_ok(i_corner_c, i_cfg.vertex_limit);

    assign accept  = i_push && !o_full;
    // Loads aimed beyond the store are taken and dropped here.
    assign enqueue = accept && (is_tri || slot_ok);

    always_comb begin
        ctl.is_tri    = is_tri;
        ctl.bad_index = is_tri && !all_ok;
        ctl.last      = i_batch_end;
        vertex.finite = i_vertex_finite;
        vertex.x      = i_vertex_x;
        vertex.y      = i_vertex_y;
        addr[0]       = is_tri ? ADDR_W'(i_corner_a) : ADDR_W'(i_vertex_slot);
        addr[1]       = ADDR_W'(i_corner_b);
        addr[2]       = ADDR_W'(i_corner_c);
    end

    assign cmd_wdata = {ctl, addr, vertex};

    tsbc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (tsbc_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enqueue),
        .i_data  (cmd_wdata),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_rdata),
        .o_empty (cmd_empty),
        .o_full  (o_full)
    );

    assign o_cmd_valid = !cmd_empty;
    assign {o_cmd_ctl, o_cmd_addr, o_cmd_vertex} = cmd_rdata;

endmodule

`default_nettype wire

/* rtl/tsbc_back.sv */
`default_nettype none

module tsbc_back #(
    parameter int unsigned VERTEX_SLOTS = tsbc_pkg::VERTEX_SLOTS_DEF,
    localparam int unsigned ADDR_W = $clog2(VERTEX_SLOTS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsbc_pkg::t_cfg                i_cfg,
    input  wire logic                          i_cmd_valid,
    input  wire tsbc_pkg::t_cmd_ctl            i_cmd_ctl,
    input  wire logic [2:0][ADDR_W-1:0]        i_cmd_addr,
    input  wire tsbc_pkg::t_vertex             i_cmd_vertex,
    output logic                               o_cmd_pop,
    input  wire logic                          i_res_pop,
    output logic                               o_res_empty,
    output tsbc_pkg::t_result                  o_result
);

    localparam int unsigned CW    = tsbc_pkg::COORD_W;
    localparam int unsigned EW    = tsbc_pkg::COORD_W + 1;
    localparam int unsigned PW    = 2 * EW;
    localparam int unsigned CNT_W = $clog2(tsbc_pkg::OUT_DEPTH + 1);
    localparam logic signed [EW-1:0] ROUND = EW'((1 << tsbc_pkg::COORD_FRAC_BITS) - 1);

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // ---------------- vertex store and read sequencer ----------------
    tsbc_pkg::t_vertex    r_vertex_mem [VERTEX_SLOTS];
    tsbc_pkg::t_vertex    r_rdata;
    tsbc_pkg::t_vertex    r_va;
    tsbc_pkg::t_vertex    r_vb;
    tsbc_pkg::t_rd_state  r_rd_state;
    tsbc_pkg::t_rd_state  n_rd_state;
    logic [ADDR_W-1:0]    r_addr_b;
    logic [ADDR_W-1:0]    r_addr_c;
    logic                 r_last;
    logic [CNT_W-1:0]     r_inflight;

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 credit;
    logic                 can_take;
    logic                 start_read;
    logic                 tri_pop;
    logic                 res_pop_fire;
    logic                 p1_load;
    logic                 p1_bad;
    logic                 p1_last;

    assign credit       = r_inflight < CNT_W'(tsbc_pkg::OUT_DEPTH);
    assign can_take     = (r_rd_state == tsbc_pkg::RD_IDLE) || (r_rd_state == tsbc_pkg::RD_CAP);
    assign tri_pop      = o_cmd_pop && i_cmd_ctl.is_tri;
    assign res_pop_fire = i_res_pop && !o_res_empty;

    always_comb begin
        n_rd_state = r_rd_state;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = i_cmd_addr[0];
        start_read = 1'b0;
        p1_load    = 1'b0;
        p1_bad     = 1'b0;
        p1_last    = r_last;
        unique case (r_rd_state)
            tsbc_pkg::RD_IDLE: begin
            end
            tsbc_pkg::RD_B: begin
                mem_re     = 1'b1;
                mem_addr   = r_addr_b;
                n_rd_state = tsbc_pkg::RD_C;
            end
            tsbc_pkg::RD_C: begin
                mem_re     = 1'b1;
                mem_addr   = r_addr_c;
                n_rd_state = tsbc_pkg::RD_CAP;
            end
            tsbc_pkg::RD_CAP: begin
                p1_load    = 1'b1;
                n_rd_state = tsbc_pkg::RD_IDLE;
            end
        endcase
        // The store port is free while idle and in the capture cycle.
        if (i_cmd_valid && can_take) begin
            if (!i_cmd_ctl.is_tri) begin
                o_cmd_pop = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = i_cmd_addr[0];
            end else if (i_cmd_ctl.bad_index) begin
                // Goes straight into the pipeline, so it must not collide
                // with a triangle being captured.
                if (r_rd_state == tsbc_pkg::RD_IDLE && credit) begin
                    o_cmd_pop = 1'b1;
                    p1_load   = 1'b1;
                    p1_bad    = 1'b1;
                    p1_last   = i_cmd_ctl.last;
                end
            end else if (credit) begin
                o_cmd_pop  = 1'b1;
                mem_re     = 1'b1;
                mem_addr   = i_cmd_addr[0];
                start_read = 1'b1;
                n_rd_state = tsbc_pkg::RD_B;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vertex_mem[mem_addr] <= i_cmd_vertex;
        end
        if (mem_re) begin
            r_rdata <= r_vertex_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_read) begin
            r_addr_b <= i_cmd_addr[1];
            r_addr_c <= i_cmd_addr[2];
            r_last   <= i_cmd_ctl.last;
        end
        if (r_rd_state == tsbc_pkg::RD_B) begin
            r_va <= r_rdata;
        end
        if (r_rd_state == tsbc_pkg::RD_C) begin
            r_vb <= r_rdata;
        end
    end

    // Every triangle holds a slot in the result queue from the moment it
    // leaves the command queue, so the pipeline below never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_state <= tsbc_pkg::RD_IDLE;
            r_inflight <= '0;
        end else begin
            r_rd_state <= n_rd_state;
            if (tri_pop && !res_pop_fire) begin
                r_inflight <= r_inflight + 1'b1;
            end else if (res_pop_fire && !tri_pop) begin
                r_inflight <= r_inflight - 1'b1;
            end
        end
    end

    // ---------------- stage 1: vertices ----------------
    logic                    r_p1_valid;
    logic                    r_p1_bad;
    logic                    r_p1_last;
    tsbc_pkg::t_vertex [2:0] r_p1_v;

    always_ff @(posedge i_clk) begin
        if (p1_load) begin
            r_p1_bad  <= p1_bad;
            r_p1_last <= p1_last;
            r_p1_v[0] <= r_va;
            r_p1_v[1] <= r_vb;
            r_p1_v[2] <= r_rdata;
        end
    end

    // ---------------- stage 2: extremes and edge differences ----------------
    logic                    r_p2_valid;
    logic                    r_p2_bad;
    logic                    r_p2_last;
    logic                    r_p2_finite;
    logic signed [CW-1:0]    r_p2_min_x;
    logic signed [CW-1:0]    r_p2_max_x;
    logic signed [CW-1:0]    r_p2_min_y;
    logic signed [CW-1:0]    r_p2_max_y;
    logic signed [EW-1:0]    r_p2_dx0;
    logic signed [EW-1:0]    r_p2_dy2;
    logic signed [EW-1:0]    r_p2_dy0;
    logic signed [EW-1:0]    r_p2_dx2;

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_p2_bad    <= r_p1_bad;
            r_p2_last   <= r_p1_last;
            r_p2_finite <= r_p1_v[0].finite && r_p1_v[1].finite && r_p1_v[2].finite;
            r_p2_min_x  <= min3(r_p1_v[0].x, r_p1_v[1].x, r_p1_v[2].x);
            r_p2_max_x  <= max3(r_p1_v[0].x, r_p1_v[1].x, r_p1_v[2].x);
            r_p2_min_y  <= min3(r_p1_v[0].y, r_p1_v[1].y, r_p1_v[2].y);
            r_p2_max_y  <= max3(r_p1_v[0].y, r_p1_v[1].y, r_p1_v[2].y);
            r_p2_dx0    <= {r_p1_v[0].x[CW-1], r_p1_v[0].x} - {r_p1_v[1].x[CW-1], r_p1_v[1].x};
            r_p2_dy2    <= {r_p1_v[2].y[CW-1], r_p1_v[2].y} - {r_p1_v[1].y[CW-1], r_p1_v[1].y};
            r_p2_dy0    <= {r_p1_v[0].y[CW-1], r_p1_v[0].y} - {r_p1_v[1].y[CW-1], r_p1_v[1].y};
            r_p2_dx2    <= {r_p1_v[2].x[CW-1], r_p1_v[2].x} - {r_p1_v[1].x[CW-1], r_p1_v[1].x};
        end
    end

    // ---------------- stage 3: box clamp and products ----------------
    logic signed [EW-1:0] min_x_e;
    logic signed [EW-1:0] max_x_e;
    logic signed [EW-1:0] min_y_e;
    logic signed [EW-1:0] max_y_e;
    logic signed [EW-1:0] floor_x;
    logic signed [EW-1:0] floor_y;
    logic signed [EW-1:0] ceil_x;
    logic signed [EW-1:0] ceil_y;
    logic signed [EW-1:0] edge_x;
    logic signed [EW-1:0] edge_y;
    logic signed [EW-1:0] box_x0;
    logic signed [EW-1:0] box_x1;
    logic signed [EW-1:0] box_y0;
    logic signed [EW-1:0] box_y1;

    assign min_x_e = {r_p2_min_x[CW-1], r_p2_min_x};
    assign max_x_e = {r_p2_max_x[CW-1], r_p2_max_x};
    assign min_y_e = {r_p2_min_y[CW-1], r_p2_min_y};
    assign max_y_e = {r_p2_max_y[CW-1], r_p2_max_y};
    // Arithmetic right shift floors; adding the fraction mask first ceils.
    assign floor_x = min_x_e >>> tsbc_pkg::COORD_FRAC_BITS;
    assign floor_y = min_y_e >>> tsbc_pkg::COORD_FRAC_BITS;
    assign ceil_x  = (max_x_e + ROUND) >>> tsbc_pkg::COORD_FRAC_BITS;
    assign ceil_y  = (max_y_e + ROUND) >>> tsbc_pkg::COORD_FRAC_BITS;
    assign edge_x  = $signed(EW'(i_cfg.frame_width)) - EW'(1);
    assign edge_y  = $signed(EW'(i_cfg.frame_height)) - EW'(1);
    assign box_x0  = floor_x[EW-1] ? '0 : floor_x;
    assign box_y0  = floor_y[EW-1] ? '0 : floor_y;
    assign box_x1  = (ceil_x > edge_x) ? edge_x : ceil_x;
    assign box_y1  = (ceil_y > edge_y) ? edge_y : ceil_y;

    logic                 r_p3_valid;
    logic                 r_p3_bad;
    logic                 r_p3_last;
    logic                 r_p3_finite;
    logic                 r_p3_empty;
    logic signed [EW-1:0] r_p3_x0;
    logic signed [EW-1:0] r_p3_x1;
    logic signed [EW-1:0] r_p3_y0;
    logic signed [EW-1:0] r_p3_y1;
    logic signed [PW-1:0] r_p3_prod0;
    logic signed [PW-1:0] r_p3_prod1;

    always_ff @(posedge i_clk) begin
        if (r_p2_valid) begin
            r_p3_bad    <= r_p2_bad;
            r_p3_last   <= r_p2_last;
            r_p3_finite <= r_p2_finite;
            r_p3_empty  <= (box_x0 > box_x1) || (box_y0 > box_y1);
            r_p3_x0     <= box_x0;
            r_p3_x1     <= box_x1;
            r_p3_y0     <= box_y0;
            r_p3_y1     <= box_y1;
            r_p3_prod0  <= r_p2_dx0 * r_p2_dy2;
            r_p3_prod1  <= r_p2_dy0 * r_p2_dx2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= p1_load;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    // ---------------- stage 4: area, decision, result queue ----------------
    logic [tsbc_pkg::AREA_W-1:0] area;
    logic                        area_zero;
    logic                        back_facing;
    tsbc_pkg::t_result           result;

    // Both products are signed, so the size casts sign-extend them.
    assign area = tsbc_pkg::AREA_W'(r_p3_prod0) - tsbc_pkg::AREA_W'(r_p3_prod1);
    assign area_zero   = (area == '0);
    assign back_facing = i_cfg.clockwise_front ? !area[tsbc_pkg::AREA_W-1]
                                               : area[tsbc_pkg::AREA_W-1];

    always_comb begin
        result            = '0;
        result.batch_last = r_p3_last;
        if (r_p3_bad) begin
            result.status = 1'b1;
        end else if (r_p3_finite) begin
            result.box_x0 = r_p3_x0[tsbc_pkg::BOX_LO_W-1:0];
            result.box_x1 = r_p3_x1[tsbc_pkg::BOX_HI_W-1:0];
            result.box_y0 = r_p3_y0[tsbc_pkg::BOX_LO_W-1:0];
            result.box_y1 = r_p3_y1[tsbc_pkg::BOX_HI_W-1:0];
            if (!r_p3_empty) begin
                result.twice_area = area;
                result.candidate  = !area_zero && !(i_cfg.cull_enable && back_facing);
            end
        end
    end

    tsbc_fifo #(
        .WIDTH ($bits(tsbc_pkg::t_result)),
        .DEPTH (tsbc_pkg::OUT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p3_valid),
        .i_data  (result),
        .i_pop   (i_res_pop),
        .o_data  (o_result),
        .o_empty (o_res_empty),
        .o_full  ()
    );

endmodule

`default_nettype wire

/* rtl/tsbc_checker.sv */
`default_nettype none

module tsbc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                push,
    input wire logic                                full,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic                                o_status,
    input wire logic                                o_candidate,
    input wire logic        [tsbc_pkg::BOX_LO_W-1:0] o_box_x0,
    input wire logic signed [tsbc_pkg::BOX_HI_W-1:0] o_box_x1,
    input wire logic        [tsbc_pkg::BOX_LO_W-1:0] o_box_y0,
    input wire logic signed [tsbc_pkg::BOX_HI_W-1:0] o_box_y1,
    input wire logic signed [tsbc_pkg::AREA_W-1:0]   o_twice_area,
    input wire logic                                o_batch_last,
    input wire logic                                psel,
    input wire logic                                penable,
    input wire logic                                pwrite,
    input wire logic        [tsbc_pkg::PADDR_W-1:0] paddr,
    input wire logic        [tsbc_pkg::PDATA_W-1:0] pwdata,
    input wire logic        [tsbc_pkg::PDATA_W-1:0] prdata,
    input wire logic                                pready
);

    logic cfg_write;
    logic addr_is_width;

    assign cfg_write     = psel && penable && pwrite && pready;
    assign addr_is_width = (paddr[tsbc_pkg::PADDR_W-1:2] == tsbc_pkg::REG_FRAME_WIDTH);

    // Reset leaves both queues empty.
    a_reset_queues: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // The head result holds until it is popped.
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_candidate)
                              && $stable(o_twice_area) && $stable(o_batch_last)))
        else $error("result changed while waiting");

    // A bad index clears every geometric field.
    a_bad_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (!o_candidate && o_twice_area == '0
                                  && o_box_x0 == '0 && o_box_x1 == '0
                                  && o_box_y0 == '0 && o_box_y1 == '0))
        else $error("bad index result carries geometry");

    // A candidate has a valid index, a nonzero area and a box that is not empty.
    a_candidate_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_candidate) |-> (!o_status && o_twice_area != '0
                                     && $signed({1'b0, o_box_x0}) <= o_box_x1
                                     && $signed({1'b0, o_box_y0}) <= o_box_y1))
        else $error("candidate with empty box or zero area");

    // A frame width write reads back on the next cycle.
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && addr_is_width ##1 addr_is_width)
            |-> (prdata == tsbc_pkg::PDATA_W'($past(pwdata[tsbc_pkg::FRAME_W-1:0]))))
        else $error("frame width readback mismatch");

endmodule

bind triangle_setup_bbox_cull tsbc_checker u_tsbc_checker (.*);

`default_nettype wire

/* tb/sv/triangle_setup_bbox_cull_tb.sv */
`timescale 1ns / 100ps

import tsbc_pkg::*;

typedef struct packed {
    t_kind                     kind;
    logic        [SLOT_W-1:0]  slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      finite;
    logic signed [IDX_W-1:0]   corner_a;
    logic signed [IDX_W-1:0]   corner_b;
    logic signed [IDX_W-1:0]   corner_c;
    logic                      last;
} setup_req_t;

class tri_setup_tracker;
    logic signed [COORD_W-1:0] vx_mem   [VERTEX_SLOTS_DEF];
    logic signed [COORD_W-1:0] vy_mem   [VERTEX_SLOTS_DEF];
    logic                      vfin_mem [VERTEX_SLOTS_DEF];
    t_cfg                      cfg;
    t_result                   pending_setups [$];
    int                        errors;

    function new();
        cfg.frame_width     = 1;
        cfg.frame_height    = 1;
        cfg.vertex_limit    = 0;
        cfg.cull_enable     = 1'b0;
        cfg.clockwise_front = 1'b0;
        errors              = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:     cfg.frame_width     = value[FRAME_W-1:0];
            REG_FRAME_HEIGHT:    cfg.frame_height    = value[FRAME_W-1:0];
            REG_VERTEX_LIMIT:    cfg.vertex_limit    = value[LIMIT_W-1:0];
            REG_CULL_ENABLE:     cfg.cull_enable     = value[0];
            REG_CLOCKWISE_FRONT: cfg.clockwise_front = value[0];
            default: ;
        endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(t_reg_idx idx);
        case (idx)
            REG_FRAME_WIDTH:     return PDATA_W'(cfg.frame_width);
            REG_FRAME_HEIGHT:    return PDATA_W'(cfg.frame_height);
            REG_VERTEX_LIMIT:    return PDATA_W'(cfg.vertex_limit);
            REG_CULL_ENABLE:     return PDATA_W'(cfg.cull_enable);
            REG_CLOCKWISE_FRONT: return PDATA_W'(cfg.clockwise_front);
            default:             return '0;
        endcase
    endfunction

    function t_result predict_setup(setup_req_t r);
        t_result res;
        longint  idx [3];
        longint  px  [3];
        longint  py  [3];
        longint  xmin, xmax, ymin, ymax;
        longint  x0, x1, y0, y1, area;
        bit      all_finite;
        res            = '0;
        res.batch_last = r.last;
        idx[0]         = longint'($signed(r.corner_a));
        idx[1]         = longint'($signed(r.corner_b));
        idx[2]         = longint'($signed(r.corner_c));
        for (int k = 0; k < 3; k++) begin
            if (idx[k] < 0 || idx[k] >= longint'(cfg.vertex_limit) ||
                idx[k] >= longint'(VERTEX_SLOTS_DEF)) begin
                res.status = 1'b1;
                return res;
            end
        end
        all_finite = 1'b1;
        for (int k = 0; k < 3; k++) begin
            px[k] = vx_mem[idx[k]];
            py[k] = vy_mem[idx[k]];
            if (!vfin_mem[idx[k]]) all_finite = 1'b0;
        end
        if (!all_finite) return res;

        xmin = px[0]; xmax = px[0];
        ymin = py[0]; ymax = py[0];
        for (int k = 1; k < 3; k++) begin
            if (px[k] < xmin) xmin = px[k];
            if (px[k] > xmax) xmax = px[k];
            if (py[k] < ymin) ymin = py[k];
            if (py[k] > ymax) ymax = py[k];
        end
        // Floor is an arithmetic shift; ceil is the negated floor of the negation.
        x0 = xmin >>> COORD_FRAC_BITS;
        y0 = ymin >>> COORD_FRAC_BITS;
        x1 = -((-xmax) >>> COORD_FRAC_BITS);
        y1 = -((-ymax) >>> COORD_FRAC_BITS);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > longint'(cfg.frame_width) - 1) x1 = longint'(cfg.frame_width) - 1;
        if (y1 > longint'(cfg.frame_height) - 1) y1 = longint'(cfg.frame_height) - 1;
        res.box_x0 = x0[BOX_LO_W-1:0];
        res.box_x1 = x1[BOX_HI_W-1:0];
        res.box_y0 = y0[BOX_LO_W-1:0];
        res.box_y1 = y1[BOX_HI_W-1:0];
        if (x0 > x1 || y0 > y1) return res;

        area = (px[0] - px[1]) * (py[2] - py[1]) - (py[0] - py[1]) * (px[2] - px[1]);
        res.twice_area = area[AREA_W-1:0];
        if (area == 0) return res;
        if (cfg.cull_enable && (cfg.clockwise_front ? area >= 0 : area <= 0)) return res;
        res.candidate = 1'b1;
        return res;
    endfunction

    function void note_request(setup_req_t r);
        if (r.kind == KIND_LOAD) begin
            vx_mem[r.slot]   = r.x;
            vy_mem[r.slot]   = r.y;
            vfin_mem[r.slot] = r.finite;
        end else begin
            pending_setups.push_back(predict_setup(r));
        end
    endfunction

    function bit field_bad(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void check_result(t_result got);
        t_result want;
        bit      bad;
        if (pending_setups.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
            errors++;
            return;
        end
        want = pending_setups.pop_front();
        bad  = field_bad("status", want.status, got.status);
        bad |= field_bad("candidate", want.candidate, got.candidate);
        bad |= field_bad("box_x0", want.box_x0, got.box_x0);
        bad |= field_bad("box_x1", want.box_x1, got.box_x1);
        bad |= field_bad("box_y0", want.box_y0, got.box_y0);
        bad |= field_bad("box_y1", want.box_y1, got.box_y1);
        bad |= field_bad("twice_area", want.twice_area, got.twice_area);
        bad |= field_bad("batch_last", want.batch_last, got.batch_last);
        if (bad) errors++;
    endfunction
endclass

module triangle_setup_bbox_cull_tb;
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic                      i_kind;
    logic        [SLOT_W-1:0]  i_vertex_slot;
    logic signed [COORD_W-1:0] i_vertex_x;
    logic signed [COORD_W-1:0] i_vertex_y;
    logic                      i_vertex_finite;
    logic signed [IDX_W-1:0]   i_corner_a;
    logic signed [IDX_W-1:0]   i_corner_b;
    logic signed [IDX_W-1:0]   i_corner_c;
    logic                      i_batch_end;
    logic                      empty;
    logic                      pop;
    logic                      o_status;
    logic                      o_candidate;
    logic        [BOX_LO_W-1:0] o_box_x0;
    logic signed [BOX_HI_W-1:0] o_box_x1;
    logic        [BOX_LO_W-1:0] o_box_y0;
    logic signed [BOX_HI_W-1:0] o_box_y1;
    logic signed [AREA_W-1:0]  o_twice_area;
    logic                      o_batch_last;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic        [PADDR_W-1:0] paddr;
    logic        [PDATA_W-1:0] pwdata;
    logic        [PDATA_W-1:0] prdata;
    logic                      pready;

    tri_setup_tracker tracker;
    bit               loaded [VERTEX_SLOTS_DEF];
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_off_cycles;
    int               cur_width;
    int               cur_height;
    int               cur_limit;

    triangle_setup_bbox_cull dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("triangle_setup_bbox_cull test failed");
        $finish;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(int span);
        case ($urandom_range(0, 9))
            0, 1:    return COORD_W'($urandom);
            2:       return {1'b1, {(COORD_W-1){1'b0}}};
            3:       return {1'b0, {(COORD_W-1){1'b1}}};
            default: return COORD_W'(int'($urandom_range(0, (span + 64) << COORD_FRAC_BITS))
                                     - (32 << COORD_FRAC_BITS));
        endcase
    endfunction

    // Returns a loaded slot below the current limit, or -1 when none turns up.
    function automatic int pick_index();
        int cand;
        int dense;
        if (cur_limit == 0) return -1;
        dense = cur_limit < 32 ? cur_limit : 32;
        for (int t = 0; t < 16; t++) begin
            cand = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_limit - 1)
                                               : $urandom_range(0, dense - 1);
            if (loaded[cand]) return cand;
        end
        return -1;
    endfunction

    function automatic bit in_window(int idx);
        return idx >= 0 && idx < cur_limit && idx < int'(VERTEX_SLOTS_DEF);
    endfunction

    function automatic setup_req_t load_req(int slot, int x, int y, bit fin);
        setup_req_t r;
        r.kind     = KIND_LOAD;
        r.slot     = SLOT_W'(slot);
        r.x        = COORD_W'(x);
        r.y        = COORD_W'(y);
        r.finite   = fin;
        r.corner_a = $urandom;
        r.corner_b = $urandom;
        r.corner_c = $urandom;
        r.last     = $urandom_range(0, 1);
        return r;
    endfunction

    function automatic setup_req_t tri_req(int a, int b, int c, bit last);
        setup_req_t r;
        r.kind     = KIND_TRI;
        r.slot     = SLOT_W'($urandom);
        r.x        = COORD_W'($urandom);
        r.y        = COORD_W'($urandom);
        r.finite   = $urandom_range(0, 1);
        r.corner_a = a;
        r.corner_b = b;
        r.corner_c = c;
        r.last     = last;
        return r;
    endfunction

    function automatic setup_req_t gen_request();
        int idx [3];
        int k;
        if ($urandom_range(0, 99) < 35) begin
            return load_req(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 31),
                            rand_coord(cur_width), rand_coord(cur_height),
                            $urandom_range(0, 9) != 0);
        end
        for (k = 0; k < 3; k++) idx[k] = pick_index();
        if ($urandom_range(0, 9) == 0) idx[1] = idx[0];
        if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0:       idx[k] = $urandom;
                1:       idx[k] = -1 - int'($urandom_range(0, 7));
                2:       idx[k] = cur_limit + int'($urandom_range(0, 3));
                default: idx[k] = int'(VERTEX_SLOTS_DEF) + int'($urandom_range(0, 1023));
            endcase
        end
        // A triangle whose indices all pass the range check must only name loaded slots.
        if (in_window(idx[0]) && in_window(idx[1]) && in_window(idx[2])) begin
            for (k = 0; k < 3; k++) begin
                if (!loaded[idx[k]]) idx[k] = pick_index();
            end
        end
        return tri_req(idx[0], idx[1], idx[2], $urandom_range(0, 1));
    endfunction

    task automatic send_request(setup_req_t r);
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= r.kind;
        i_vertex_slot   <= r.slot;
        i_vertex_x      <= r.x;
        i_vertex_y      <= r.y;
        i_vertex_finite <= r.finite;
        i_corner_a      <= r.corner_a;
        i_corner_b      <= r.corner_b;
        i_corner_c      <= r.corner_c;
        i_batch_end     <= r.last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.note_request(r);
        if (r.kind == KIND_LOAD) loaded[r.slot] = 1'b1;
    endtask

    // Back-to-back transfers keep psel high; the caller returns the bus to idle.
    task automatic reg_write(t_reg_idx idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic reg_read(t_reg_idx idx, output logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(4 * int'(idx));
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
    endtask

    task automatic check_regs();
        logic [PDATA_W-1:0] rd;
        t_reg_idx           ri;
        for (int i = 0; i <= int'(REG_CLOCKWISE_FRONT); i++) begin
            ri = t_reg_idx'(i);
            reg_read(ri, rd);
            if (rd !== tracker.reg_value(ri)) begin
                $display("%0t: %s readback mismatch: expected 0x%0h, actual 0x%0h",
                         $time, ri.name(), tracker.reg_value(ri), rd);
                tracker.errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Loads give no result, so the wait goes on past the last result to let them retire.
    task automatic drain();
        while (tracker.pending_setups.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic configure(int fw, int fh, int lim, bit cull, bit cw);
        drain();
        reg_write(REG_FRAME_WIDTH, fw);
        reg_write(REG_FRAME_HEIGHT, fh);
        reg_write(REG_VERTEX_LIMIT, lim);
        reg_write(REG_CULL_ENABLE, cull);
        reg_write(REG_CLOCKWISE_FRONT, cw);
        cur_width  = fw;
        cur_height = fh;
        cur_limit  = lim;
        check_regs();
    endtask

    task automatic directed();
        send_request(load_req(0, 2688, 5184, 1'b1));
        send_request(load_req(1, 25600, 7680, 1'b1));
        send_request(load_req(2, 12992, 51328, 1'b1));
        send_request(load_req(3, -8388608, -8388608, 1'b1));
        send_request(load_req(4, 8388607, 8388607, 1'b1));
        send_request(load_req(5, 1280, 1280, 1'b0));
        send_request(load_req(6, 179200, 128000, 1'b1));
        send_request(load_req(7, 51200, 15360, 1'b1));
        send_request(load_req(8, 76800, 23040, 1'b1));
        send_request(load_req(9, -5248, -5248, 1'b1));
        send_request(load_req(1023, 81952, 61664, 1'b1));
        // Both windings, extreme coordinates, a non-finite vertex, a box past the
        // frame edge, collinear vertices, a box clipped at the origin, and bad indices.
        send_request(tri_req(0, 1, 2, 1'b0));
        send_request(tri_req(0, 2, 1, 1'b1));
        send_request(tri_req(3, 4, 0, 1'b0));
        send_request(tri_req(0, 1, 5, 1'b0));
        send_request(tri_req(6, 6, 6, 1'b1));
        send_request(tri_req(1, 7, 8, 1'b0));
        send_request(tri_req(9, 0, 1, 1'b0));
        send_request(tri_req(-1, 0, 1, 1'b1));
        send_request(tri_req(0, 1024, 1, 1'b0));
        send_request(tri_req(0, 1, 32'h7fff_ffff, 1'b0));
        send_request(tri_req(0, 1023, 2, 1'b1));
        send_request(tri_req(int'(32'h8000_0000), 0, 1, 1'b1));
        push <= 1'b0;
    endtask

    task automatic run_phase(int fw, int fh, int lim, bit cull, bit cw,
                             int send_pct, int recv_pct, int count, int hold);
        configure(fw, fh, lim, cull, cw);
        send_idle_pct   = send_pct;
        recv_stall_pct  = recv_pct;
        hold_off_cycles = hold;
        for (int n = 0; n < count; n++) send_request(gen_request());
        push <= 1'b0;
    endtask

    initial begin : result_sink
        t_result got;
        bit      take;
        int      stall;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                take = $urandom_range(1, 100) > recv_stall_pct;
                pop <= take;
                @(posedge i_clk);
                if (take && empty === 1'b0) begin
                    got.status     = o_status;
                    got.candidate  = o_candidate;
                    got.box_x0     = o_box_x0;
                    got.box_x1     = o_box_x1;
                    got.box_y0     = o_box_y0;
                    got.box_y1     = o_box_y1;
                    got.twice_area = o_twice_area;
                    got.batch_last = o_batch_last;
                    tracker.check_result(got);
                end
            end
        end
    end

    initial begin
        tracker         = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_kind          <= KIND_LOAD;
        i_vertex_slot   <= '0;
        i_vertex_x      <= '0;
        i_vertex_y      <= '0;
        i_vertex_finite <= 1'b0;
        i_corner_a      <= '0;
        i_corner_b      <= '0;
        i_corner_c      <= '0;
        i_batch_end     <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_regs();

        configure(640, 480, 1024, 1'b1, 1'b0);
        directed();

        run_phase(640, 480, 1024, 1'b0, 1'b0, 0, 0, 200, 0);
        run_phase(1, 1, 1024, 1'b1, 1'b1, 47, 0, 150, 0);
        run_phase(4096, 4096, 1024, 1'b1, 1'b0, 0, 47, 200, 0);
        run_phase(0, 4096, 32, 1'b0, 1'b0, 33, 33, 120, 0);
        run_phase(320, 200, 16, 1'b1, 1'b1, 0, 0, 200, 300);
        run_phase(4096, 1, 0, 1'b0, 1'b1, 33, 33, 60, 0);
        run_phase(1920, 1080, 1024, 1'b1, 1'b0, 33, 33, 300, 0);
        run_phase(640, 480, 1024, 1'b1, 1'b1, 0, 47, 200, 0);

        drain();
        if (tracker.errors == 0) begin
            $display("triangle_setup_bbox_cull test passed");
        end else begin
            $display("triangle_setup_bbox_cull test failed");
        end
        $finish;
    end
endmodule

/* triangle_setup_bbox_cull.f */
rtl/tsbc_pkg.sv
rtl/tsbc_fifo.sv
rtl/tsbc_front.sv
rtl/tsbc_back.sv
rtl/triangle_setup_bbox_cull.sv
rtl/tsbc_checker.sv
tb/sv/triangle_setup_bbox_cull_tb.sv
